// ===== rtl/core/lfbp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lfbp_pkg
// Shared types and constants for the LSB-first field bit packer.
// ---------------------------------------------------------------------------
package lfbp_pkg;

	localparam logic [2:0] ACT_RAW     = 3'd0;
	localparam logic [2:0] ACT_VARINT  = 3'd1;
	localparam logic [2:0] ACT_UBITINT = 3'd2;
	localparam logic [2:0] ACT_UBITVAR = 3'd3;
	localparam logic [2:0] ACT_INDEX   = 3'd4;
	localparam logic [2:0] ACT_FLUSH   = 3'd5;

	localparam int BITS_W = 64;
	localparam int LEN_W  = 7;
	localparam int ACC_W  = 71;
	localparam int CNT_W  = 7;

	localparam logic [31:0] LIM_4  = 32'hF;
	localparam logic [31:0] LIM_8  = 32'hFF;
	localparam logic [31:0] LIM_12 = 32'hFFF;
	localparam logic [31:0] LIM_5  = 32'h1F;
	localparam logic [31:0] LIM_7  = 32'h7F;
	localparam logic [31:0] LIM_9  = 32'h1FF;
	localparam logic [31:0] END_DIFF = 32'hFFF;
	localparam logic [31:0] SHORT_LIM = 32'd8;

	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic [LEN_W-1:0]  len;
		logic              flush;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} wr_t;

	typedef struct packed {
		logic   avail;
		entry_t entry;
	} rd_t;

endpackage
`default_nettype wire

// ===== rtl/core/lfbp_in_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lfbp_in_if
// Field item channel: one field to encode per item.
// ---------------------------------------------------------------------------
interface lfbp_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [63:0] field_value;
	logic [6:0]  raw_width;
	logic signed [31:0] next_index;
	logic signed [31:0] prior_index;
	logic        short_form;

	modport source(output valid, action, field_value, raw_width, next_index, prior_index,
		short_form, input ready);
	modport sink(input valid, action, field_value, raw_width, next_index, prior_index,
		short_form, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lfbp_out_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lfbp_out_if
// Packed byte channel: one byte per item.
// ---------------------------------------------------------------------------
interface lfbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [3:0] used_bits;
	logic       run_end;

	modport source(output valid, out_byte, used_bits, run_end, input ready);
	modport sink(input valid, out_byte, used_bits, run_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lfbp_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lfbp_front
// Accepts field items and encodes each into a bit string and its length.
// ---------------------------------------------------------------------------
module lfbp_front (
	lfbp_in_if.sink        fields,
	input  logic           full,
	output lfbp_pkg::wr_t  wr
);

	lfbp_pkg::entry_t enc;
	logic [31:0] v;
	logic [34:0] vx;
	logic [31:0] diff;
	logic [6:0]  w;
	logic [2:0]  n;
	logic [1:0]  sel;
	logic [1:0]  osel;
	logic [13:0] old_bits;
	logic [3:0]  old_len;
	logic [63:0] mask;

	assign fields.ready = !full;
	assign wr.push  = fields.valid && !full;
	assign wr.entry = enc;

	always_comb begin
		v  = fields.field_value[31:0];
		vx = {3'b000, v};
		w  = (fields.raw_width > 7'd64) ? 7'd64 : fields.raw_width;
		mask = (w == 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);

		if (v[31:7] == '0)
			n = 3'd1;
		else if (v[31:14] == '0)
			n = 3'd2;
		else if (v[31:21] == '0)
			n = 3'd3;
		else if (v[31:28] == '0)
			n = 3'd4;
		else
			n = 3'd5;

		if (v <= lfbp_pkg::LIM_4)
			sel = 2'd0;
		else if (v <= lfbp_pkg::LIM_8)
			sel = 2'd1;
		else if (v <= lfbp_pkg::LIM_12)
			sel = 2'd2;
		else
			sel = 2'd3;

		if (fields.next_index == -32'sd1)
			diff = lfbp_pkg::END_DIFF;
		else
			diff = $unsigned(fields.next_index) - $unsigned(fields.prior_index) - 32'd1;

		if (diff <= lfbp_pkg::LIM_5)
			osel = 2'd0;
		else if (diff <= lfbp_pkg::LIM_7)
			osel = 2'd1;
		else if (diff <= lfbp_pkg::LIM_9)
			osel = 2'd2;
		else
			osel = 2'd3;
		old_bits = {diff[11:5], osel, diff[4:0]};
		unique case (osel)
			2'd0:    old_len = 4'd7;
			2'd1:    old_len = 4'd9;
			2'd2:    old_len = 4'd11;
			default: old_len = 4'd14;
		endcase

		enc = '0;
		unique case (fields.action) inside
			lfbp_pkg::ACT_RAW: begin
				enc.bits = fields.field_value & mask;
				enc.len  = w;
			end
			lfbp_pkg::ACT_VARINT: begin
				for (int k = 0; k < 5; k++) begin
					if (3'(k) < n)
						enc.bits[8*k +: 8] = {(3'(k) < n - 3'd1), vx[7*k +: 7]};
				end
				enc.len = {1'b0, n, 3'b000};
			end
			lfbp_pkg::ACT_UBITINT, lfbp_pkg::ACT_UBITVAR: begin
				if (fields.action == lfbp_pkg::ACT_UBITINT)
					enc.bits = {30'b0, v[31:4], sel, v[3:0]};
				else
					enc.bits = {30'b0, v, sel};
				unique case (sel)
					2'd0:    enc.len = 7'd6;
					2'd1:    enc.len = 7'd10;
					2'd2:    enc.len = 7'd14;
					default: enc.len = 7'd34;
				endcase
			end
			lfbp_pkg::ACT_INDEX: begin
				if (!fields.short_form) begin
					enc.bits = {50'b0, old_bits};
					enc.len  = {3'b000, old_len};
				end else if (diff == '0) begin
					enc.bits = 64'd1;
					enc.len  = 7'd1;
				end else if (diff[31] || diff < lfbp_pkg::SHORT_LIM) begin
					enc.bits = {59'b0, diff[2:0], 2'b10};
					enc.len  = 7'd5;
				end else begin
					enc.bits = {48'b0, old_bits, 2'b00};
					enc.len  = {3'b000, old_len} + 7'd2;
				end
			end
			lfbp_pkg::ACT_FLUSH: begin
				enc.flush = 1'b1;
			end
			default: begin
				enc = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/lfbp_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lfbp_queue
// Two-entry queue of encoded bit strings between front and back.
// ---------------------------------------------------------------------------
module lfbp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  lfbp_pkg::wr_t wr,
	input  logic          pop,
	output logic          full,
	output lfbp_pkg::rd_t rd
);

	lfbp_pkg::entry_t slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd.avail = (cnt_q != 2'd0);
	assign rd.entry = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr.push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, wr.push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push)
			slot_q[wptr_q] <= wr.entry;
	end

endmodule
`default_nettype wire

// ===== rtl/core/lfbp_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lfbp_back
// Appends encoded bits after the carry and gives out bytes one per cycle while the receiver takes them.
// ---------------------------------------------------------------------------
module lfbp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  lfbp_pkg::rd_t rd,
	output logic          pop,
	lfbp_out_if.source    stream
);

	logic [lfbp_pkg::ACC_W-1:0] acc_q;
	logic [lfbp_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       flush_q;
	logic                       out_valid_q;
	logic [7:0]                 byte_q;
	logic [3:0]                 used_q;
	logic                       end_q;

	logic                       slot_free;
	logic                       emit_full;
	logic                       emit_part;
	logic [lfbp_pkg::ACC_W-1:0] merged;
	logic [lfbp_pkg::CNT_W-1:0] total;
	logic [lfbp_pkg::CNT_W-1:0] rem;

	assign slot_free = !out_valid_q || stream.ready;
	assign pop       = !busy_q && rd.avail;
	assign merged    = acc_q | (lfbp_pkg::ACC_W'(rd.entry.bits) << cnt_q[2:0]);
	assign total     = cnt_q + rd.entry.len;
	assign rem       = cnt_q - 7'd8;
	assign emit_full = busy_q && (cnt_q >= 7'd8) && slot_free;
	assign emit_part = busy_q && (cnt_q < 7'd8) && slot_free;

	assign stream.valid     = out_valid_q;
	assign stream.out_byte  = byte_q;
	assign stream.used_bits = used_q;
	assign stream.run_end   = end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q   <= merged;
				cnt_q   <= total;
				flush_q <= rd.entry.flush;
				busy_q  <= rd.entry.flush ? (cnt_q != '0) : (total >= 7'd8);
			end else if (emit_full) begin
				acc_q  <= acc_q >> 8;
				cnt_q  <= rem;
				busy_q <= (rem >= 7'd8);
			end else if (emit_part) begin
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b0;
			end
			if (emit_full || emit_part)
				out_valid_q <= 1'b1;
			else if (stream.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_full || emit_part) begin
			byte_q <= acc_q[7:0];
			used_q <= emit_full ? 4'd8 : {1'b0, cnt_q[2:0]};
			end_q  <= emit_full ? ((rem < 7'd8) && !flush_q) : 1'b1;
		end
	end

	a_idle_carry: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q < 7'd8)
		else $error("carry holds a full byte while idle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 7'd71)
		else $error("pending bit count out of range");

	a_partial_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && used_q != 4'd8 |-> end_q)
		else $error("partial byte not marked last");

endmodule
`default_nettype wire

// ===== rtl/core/lsb_first_field_bit_packer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lsb_first_field_bit_packer
// Packs encoded fields into a byte stream, least significant bit first.
// ---------------------------------------------------------------------------
// The front encodes one item per cycle into a two-entry queue while the queue
// is not full. The back end loads a queued item behind the pending carry, then
// gives out the bytes it completes (0 to 8 per item) one per cycle while the
// receiver takes them, and loads no new item until those bytes are out. The
// single-byte output register and the byte-wide shift of the carry set that
// rate. A flush gives out the partial byte, zero padded, with its bit count.
// ---------------------------------------------------------------------------
module lsb_first_field_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	lfbp_in_if.sink     fields,
	lfbp_out_if.source  stream
);

	lfbp_pkg::wr_t wr;
	lfbp_pkg::rd_t rd;
	logic          full;
	logic          pop;

	lfbp_front u_front (
		.fields (fields),
		.full   (full),
		.wr     (wr)
	);

	lfbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.full   (full),
		.rd     (rd)
	);

	lfbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.pop    (pop),
		.stream (stream)
	);

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// Self-checking regression for the LSB-first field bit packer. A directed
// table covers raw widths at the extremes, every encoding and some of their
// size classes, field-index deltas in both forms, flushes and an unused
// action code. A random part follows under several sender and receiver idling
// mixes, including one long receiver hold-off. Every output byte is compared
// with the table's known bytes or else a bit-level packer model in the bench.
// ---------------------------------------------------------------------------
module testbench;

	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam int PREDICT = -1;
	localparam int RANDOM_ITEMS = 272;
	localparam int PHASE_COUNT = 4;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [2:0]         action;
		logic [63:0]        field_value;
		logic [6:0]         raw_width;
		logic signed [31:0] next_index;
		logic signed [31:0] prior_index;
		logic               short_form;
	} field_t;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] used;
		logic       last;
	} byte_t;

	typedef struct packed {
		field_t      f;
		int          n_known;
		logic [63:0] known_bytes;
		logic [3:0]  known_used;
	} dir_row_t;

	logic clk;
	logic arst_n;

	lfbp_in_if  fields();
	lfbp_out_if stream();

	lsb_first_field_bit_packer uut (
		.clk   (clk),
		.arst_n(arst_n),
		.fields(fields),
		.stream(stream)
	);

	logic [7:0] pack_acc;
	int         pack_cnt;
	byte_t      item_bytes[$];
	byte_t      expected_bytes[$];
	int         failures;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_asked;

	dir_row_t dir_rows [27] = '{
		'{'{lfbp_pkg::ACT_RAW, 64'hA5, 7'd8, 32'sd0, 32'sd0, 1'b0}, 1, 64'hA5, 4'd8},
		'{'{lfbp_pkg::ACT_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 32'sd0, 32'sd0, 1'b0},
			8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8},
		'{'{lfbp_pkg::ACT_RAW, 64'h3, 7'd0, 32'sd0, 32'sd0, 1'b0}, 0, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_RAW, 64'h0123_4567_89AB_CDEF, 7'd127, 32'sd0, 32'sd0, 1'b0},
			8, 64'h0123_4567_89AB_CDEF, 4'd8},
		'{'{lfbp_pkg::ACT_FLUSH, 64'd0, 7'd0, 32'sd0, 32'sd0, 1'b0}, 0, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_RAW, 64'h5, 7'd3, 32'sd0, 32'sd0, 1'b0}, 0, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_FLUSH, 64'd0, 7'd0, 32'sd0, 32'sd0, 1'b0}, 1, 64'h05, 4'd3},
		'{'{ACT_SPARE6, 64'hFF, 7'd8, 32'sd0, 32'sd0, 1'b0}, 0, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_VARINT, 64'd0, 7'd0, 32'sd0, 32'sd0, 1'b0}, 1, 64'h00, 4'd8},
		'{'{lfbp_pkg::ACT_VARINT, 64'hFFFF_FFFF, 7'd0, 32'sd0, 32'sd0, 1'b0},
			5, 64'h0000_000F_FFFF_FFFF, 4'd8},
		'{'{lfbp_pkg::ACT_VARINT, 64'd300, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_UBITINT, 64'hF, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_UBITINT, 64'hFF, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_UBITINT, 64'hFFF, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_UBITINT, 64'hFFFF_FFFF, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_UBITVAR, 64'h10, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_UBITVAR, 64'h1000, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_UBITVAR, 64'hFFFF_FFFF, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_INDEX, 64'd0, 7'd0, -32'sd1, 32'sd3, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_INDEX, 64'd0, 7'd0, 32'sd6, 32'sd5, 1'b1},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_INDEX, 64'd0, 7'd0, 32'sd0, 32'sd5, 1'b1},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_INDEX, 64'd0, 7'd0, 32'sd0, 32'sd5, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_INDEX, 64'd0, 7'd0, 32'sd100, 32'sd0, 1'b1},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_INDEX, 64'd0, 7'd0, 32'sd41, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_INDEX, 64'd0, 7'd0, 32'sd201, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_INDEX, 64'd0, 7'd0, 32'sh7FFF_FFFF, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0},
		'{'{lfbp_pkg::ACT_FLUSH, 64'd0, 7'd0, 32'sd0, 32'sd0, 1'b0},
			PREDICT, 64'd0, 4'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("lsb_first_field_bit_packer regression: fail");
		$finish;
	end

	task automatic give_byte(input logic [7:0] data, input int used);
		byte_t b;
		b.data = data;
		b.used = 4'(used);
		b.last = 1'b0;
		item_bytes.push_back(b);
	endtask

	task automatic shift_in(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) begin
			pack_acc[pack_cnt] = v[i];
			pack_cnt++;
			if (pack_cnt == 8) begin
				give_byte(pack_acc, 8);
				pack_acc = 8'd0;
				pack_cnt = 0;
			end
		end
	endtask

	task automatic pack_index(input logic [31:0] nx, input logic [31:0] pr, input logic sf);
		logic [31:0] diff;
		diff = (nx == 32'hFFFF_FFFF) ? lfbp_pkg::END_DIFF : nx - pr - 32'd1;
		if (sf) begin
			if (diff == 32'd0) begin
				shift_in(64'd1, 1);
				return;
			end
			shift_in(64'd0, 1);
			if (diff[31] || diff < lfbp_pkg::SHORT_LIM) begin
				shift_in(64'd1, 1);
				shift_in(64'(diff[2:0]), 3);
				return;
			end
			shift_in(64'd0, 1);
		end
		shift_in(64'(diff[4:0]), 5);
		if (diff <= lfbp_pkg::LIM_5) begin
			shift_in(64'd0, 2);
		end else if (diff <= lfbp_pkg::LIM_7) begin
			shift_in(64'd1, 2);
			shift_in(64'(diff[6:5]), 2);
		end else if (diff <= lfbp_pkg::LIM_9) begin
			shift_in(64'd2, 2);
			shift_in(64'(diff[8:5]), 4);
		end else begin
			shift_in(64'd3, 2);
			shift_in(64'(diff[11:5]), 7);
		end
	endtask

	task automatic pack_field(input field_t f);
		logic [31:0] v;
		logic [31:0] grp;
		v = f.field_value[31:0];
		item_bytes.delete();
		case (f.action)
			lfbp_pkg::ACT_RAW: begin
				shift_in(f.field_value, (f.raw_width > 7'd64) ? 64 : int'(f.raw_width));
			end
			lfbp_pkg::ACT_VARINT: begin
				for (int k = 0; k < 5; k++) begin
					grp = v & 32'h7F;
					v = v >> 7;
					if (v == 32'd0) begin
						shift_in(64'(grp), 8);
						break;
					end
					shift_in(64'(grp | 32'h80), 8);
				end
			end
			lfbp_pkg::ACT_UBITINT: begin
				shift_in(64'(v[3:0]), 4);
				if (v <= lfbp_pkg::LIM_4) begin
					shift_in(64'd0, 2);
				end else if (v <= lfbp_pkg::LIM_8) begin
					shift_in(64'd1, 2);
					shift_in(64'(v >> 4), 4);
				end else if (v <= lfbp_pkg::LIM_12) begin
					shift_in(64'd2, 2);
					shift_in(64'(v >> 4), 8);
				end else begin
					shift_in(64'd3, 2);
					shift_in(64'(v >> 4), 28);
				end
			end
			lfbp_pkg::ACT_UBITVAR: begin
				if (v <= lfbp_pkg::LIM_4) begin
					shift_in(64'd0, 2);
					shift_in(64'(v), 4);
				end else if (v <= lfbp_pkg::LIM_8) begin
					shift_in(64'd1, 2);
					shift_in(64'(v), 8);
				end else if (v <= lfbp_pkg::LIM_12) begin
					shift_in(64'd2, 2);
					shift_in(64'(v), 12);
				end else begin
					shift_in(64'd3, 2);
					shift_in(64'(v), 32);
				end
			end
			lfbp_pkg::ACT_INDEX: begin
				pack_index(f.next_index, f.prior_index, f.short_form);
			end
			lfbp_pkg::ACT_FLUSH: begin
				if (pack_cnt != 0) begin
					give_byte(pack_acc, pack_cnt);
					pack_acc = 8'd0;
					pack_cnt = 0;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic file_results();
		byte_t b;
		if (item_bytes.size() != 0)
			item_bytes[item_bytes.size() - 1].last = 1'b1;
		while (item_bytes.size() != 0) begin
			b = item_bytes.pop_front();
			expected_bytes.push_back(b);
		end
	endtask

	function automatic field_t random_field();
		field_t f;
		logic [31:0] pr;
		logic [31:0] nx;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			f.action = lfbp_pkg::ACT_RAW;
		else if (pick < 42)
			f.action = lfbp_pkg::ACT_VARINT;
		else if (pick < 54)
			f.action = lfbp_pkg::ACT_UBITINT;
		else if (pick < 66)
			f.action = lfbp_pkg::ACT_UBITVAR;
		else if (pick < 88)
			f.action = lfbp_pkg::ACT_INDEX;
		else if (pick < 96)
			f.action = lfbp_pkg::ACT_FLUSH;
		else
			f.action = $urandom_range(1) ? ACT_SPARE7 : ACT_SPARE6;
		f.field_value = {$urandom, $urandom} >> $urandom_range(63);
		f.raw_width = ($urandom_range(15) == 0) ? 7'($urandom_range(127))
			: 7'($urandom_range(1, 64));
		pr = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
		case ($urandom_range(4))
			0: nx = 32'hFFFF_FFFF;
			1: nx = pr + 32'd1;
			2: nx = pr + $urandom_range(12) - 32'd3;
			3: nx = pr + $urandom_range(5000);
			default: nx = $urandom;
		endcase
		f.next_index = nx;
		f.prior_index = pr;
		f.short_form = 1'($urandom_range(1));
		return f;
	endfunction

	task automatic drive_field(input field_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			fields.valid <= 1'b0;
			@(posedge clk);
		end
		fields.valid       <= 1'b1;
		fields.action      <= f.action;
		fields.field_value <= f.field_value;
		fields.raw_width   <= f.raw_width;
		fields.next_index  <= f.next_index;
		fields.prior_index <= f.prior_index;
		fields.short_form  <= f.short_form;
		do
			@(posedge clk);
		while (!fields.ready);
	endtask

	initial begin : byte_sink
		int hold_left;
		int hold_seen;
		byte_t want;
		hold_left = 0;
		hold_seen = 0;
		stream.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && stream.valid && stream.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte %0h", stream.out_byte);
					failures++;
				end else begin
					want = expected_bytes.pop_front();
					if (stream.out_byte !== want.data) begin
						$error("out_byte: expected %0h, got %0h", want.data, stream.out_byte);
						failures++;
					end
					if (stream.used_bits !== want.used) begin
						$error("used_bits: expected %0d, got %0d", want.used, stream.used_bits);
						failures++;
					end
					if (stream.run_end !== want.last) begin
						$error("run_end: expected %0b, got %0b", want.last, stream.run_end);
						failures++;
					end
				end
			end
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stream.ready <= 1'b0;
			end else begin
				stream.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : field_source
		field_t f;
		int sent;
		failures = 0;
		hold_asked = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pack_acc = 8'd0;
		pack_cnt = 0;
		arst_n = 1'b0;
		fields.valid       <= 1'b0;
		fields.action      <= lfbp_pkg::ACT_RAW;
		fields.field_value <= 64'd0;
		fields.raw_width   <= 7'd0;
		fields.next_index  <= 32'sd0;
		fields.prior_index <= 32'sd0;
		fields.short_form  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			drive_field(dir_rows[r].f);
			pack_field(dir_rows[r].f);
			if (dir_rows[r].n_known != PREDICT) begin
				item_bytes.delete();
				for (int k = 0; k < dir_rows[r].n_known; k++)
					give_byte(dir_rows[r].known_bytes[8*k +: 8],
						(k == dir_rows[r].n_known - 1) ? int'(dir_rows[r].known_used) : 8);
			end
			file_results();
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			// stall the output long enough for the input to back up
			if (p == 0)
				hold_asked++;
			sent = 0;
			while (sent < RANDOM_ITEMS / PHASE_COUNT) begin
				f = random_field();
				drive_field(f);
				pack_field(f);
				file_results();
				if (f.action != ACT_SPARE6 && f.action != ACT_SPARE7)
					sent++;
			end
		end
		fields.valid <= 1'b0;

		for (int c = 0; c < 50000 && expected_bytes.size() != 0; c++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_bytes.size());
			failures++;
		end
		if (failures == 0)
			$display("lsb_first_field_bit_packer regression: pass");
		else
			$display("lsb_first_field_bit_packer regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

// ===== lsb_first_field_bit_packer.f =====
rtl/core/lfbp_pkg.sv
rtl/core/lfbp_in_if.sv
rtl/core/lfbp_out_if.sv
rtl/core/lfbp_front.sv
rtl/core/lfbp_queue.sv
rtl/core/lfbp_back.sv
rtl/core/lsb_first_field_bit_packer.sv
dv/testbench.sv
